// ===== hdl/bht_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// bht_pkg: shared types and constants of the bucket hash table
// Request and status codes, register indexes, sequencer states, shared unit
// operations and the memory control group.
// ----------------------------------------------------------------------------
package bht_pkg;

    // default sizing
    localparam int BUCKETS_DEF     = 64;
    localparam int WAYS_DEF        = 4;
    localparam int KEY_BYTES_DEF   = 8;
    localparam int HANDLE_BITS_DEF = 16;

    // field widths
    localparam int KEY_W      = 64;
    localparam int HANDLE_W   = 16;
    localparam int HASH_W     = 32;
    localparam int BC_W       = 7;
    localparam int KB_W       = 4;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 7;

    // two remainder bits per modulo step
    localparam int MOD_STEPS = HASH_W / 2;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_BUCKET_COUNT = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_KEY_BYTES    = 1'd1;

    // register reset values
    localparam logic [BC_W-1:0] BUCKET_COUNT_RST = 7'd64;
    localparam logic [KB_W-1:0] KEY_BYTES_RST    = 4'd4;

    // request codes
    localparam logic [1:0] REQ_LOOKUP = 2'd0;
    localparam logic [1:0] REQ_ADD    = 2'd1;
    localparam logic [1:0] REQ_DELETE = 2'd2;

    // status codes
    localparam logic [1:0] STS_OK        = 2'd0;
    localparam logic [1:0] STS_NOT_FOUND = 2'd1;
    localparam logic [1:0] STS_DUPLICATE = 2'd2;
    localparam logic [1:0] STS_FULL      = 2'd3;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_HASH,
        ST_MOD,
        ST_BASE,
        ST_ROW,
        ST_RD,
        ST_CMP,
        ST_FIN
    } t_state;

    typedef enum logic [1:0] {
        ALU_NOP,
        ALU_CLR,
        ALU_HASH,
        ALU_MOD
    } t_alu_op;

    typedef struct packed {
        logic row_rd;
        logic row_we;
        logic slot_rd;
        logic slot_we;
    } t_st_ctrl;

endpackage
`default_nettype wire

// ===== hdl/bucket_hash_table_top.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// bucket_hash_table_top: keyed table engine, lookup / add / delete
// One item at a time; the next input beat is taken only once the sequencer is
// back in ST_IDLE after a result is registered, and an earlier result that is
// not yet taken holds the sequencer in ST_FIN. The shared hash/modulo unit (kb
// hash steps, kb being the effective key byte count, 16 modulo steps) and the
// way-by-way slot scan (a read state, then a compare state per way) do the work.
// Reset: synchronous, active low; the valid rows are then swept clear, and while
// the sweep runs no input beat is taken (config writes still are).
// ----------------------------------------------------------------------------
module bucket_hash_table_top #(
    parameter int BUCKETS     = bht_pkg::BUCKETS_DEF,
    parameter int WAYS        = bht_pkg::WAYS_DEF,
    parameter int KEY_BYTES   = bht_pkg::KEY_BYTES_DEF,
    parameter int HANDLE_BITS = bht_pkg::HANDLE_BITS_DEF
) (
    input  wire                                i_clk,
    input  wire                                i_rst_n,
    // request channel
    input  wire                                i_in_valid,
    output logic                               o_in_ready,
    input  wire  [1:0]                         i_req_type,
    input  wire  [bht_pkg::KEY_W-1:0]          i_key,
    input  wire  [bht_pkg::HANDLE_W-1:0]       i_handle,
    // result channel
    output logic                               o_out_valid,
    input  wire                                i_out_ready,
    output logic [1:0]                         o_status,
    output logic [bht_pkg::HANDLE_W-1:0]       o_found_handle,
    // config write port
    input  wire                                i_cfg_we,
    input  wire  [bht_pkg::CFG_IDX_W-1:0]      i_cfg_idx,
    input  wire  [bht_pkg::CFG_DATA_W-1:0]     i_cfg_data
);

    localparam int SLOTS  = BUCKETS * WAYS;
    localparam int BKT_W  = (BUCKETS > 1) ? $clog2(BUCKETS) : 1;
    localparam int SLOT_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int WAY_W  = (WAYS > 1) ? $clog2(WAYS) : 1;
    localparam int KW     = 8 * KEY_BYTES;
    // handle bits that pass the 16-bit field
    localparam int HS     = (HANDLE_BITS < bht_pkg::HANDLE_W) ? HANDLE_BITS
                                                               : bht_pkg::HANDLE_W;
    // largest usable bucket count: the register is 7 bits wide
    localparam int BMAX   = (BUCKETS < 127) ? BUCKETS : 127;

    // ------------------------------------------------------------------
    // config registers and their effective values
    // ------------------------------------------------------------------
    logic [bht_pkg::BC_W-1:0] r_bc;
    logic [bht_pkg::KB_W-1:0] r_kb;
    logic [bht_pkg::BC_W-1:0] bc_eff;
    logic [bht_pkg::KB_W-1:0] kb_eff;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bc <= bht_pkg::BUCKET_COUNT_RST;
            r_kb <= bht_pkg::KEY_BYTES_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                bht_pkg::REG_BUCKET_COUNT: r_bc <= i_cfg_data[bht_pkg::BC_W-1:0];
                bht_pkg::REG_KEY_BYTES:    r_kb <= i_cfg_data[bht_pkg::KB_W-1:0];
            endcase
        end
    end

    // zero acts as one, anything above the table size is clamped
    always_comb begin
        if (r_bc == '0) begin
            bc_eff = 7'd1;
        end else if (32'(r_bc) > BMAX) begin
            bc_eff = 7'(BMAX);
        end else begin
            bc_eff = r_bc;
        end
        if (r_kb == '0) begin
            kb_eff = 4'd1;
        end else if (32'(r_kb) > KEY_BYTES) begin
            kb_eff = 4'(KEY_BYTES);
        end else begin
            kb_eff = r_kb;
        end
    end

    // ------------------------------------------------------------------
    // sequencer registers
    // ------------------------------------------------------------------
    bht_pkg::t_state          r_state, n_state;
    logic [4:0]               r_cnt, n_cnt;
    logic [1:0]               r_req, n_req;
    logic [bht_pkg::KEY_W-1:0] r_key, n_key;
    logic [HANDLE_BITS-1:0]   r_handle, n_handle;
    logic [BKT_W-1:0]         r_bucket, n_bucket;
    logic [SLOT_W-1:0]        r_base, n_base;
    logic [WAY_W-1:0]         r_way, n_way;
    logic                     r_hit, n_hit;
    logic [WAY_W-1:0]         r_hit_way, n_hit_way;
    logic                     r_free, n_free;
    logic [WAY_W-1:0]         r_free_way, n_free_way;
    logic [HANDLE_BITS-1:0]   r_fhandle, n_fhandle;
    logic                     r_out_valid, n_out_valid;
    logic [1:0]               r_status, n_status;
    logic [bht_pkg::HANDLE_W-1:0] r_found, n_found;

    // shared unit and storage hookup
    bht_pkg::t_alu_op         alu_op;
    logic [bht_pkg::BC_W-1:0] alu_rem;
    bht_pkg::t_st_ctrl        st_ctrl;
    logic [SLOT_W-1:0]        st_slot;
    logic [WAYS-1:0]          st_row_wdata;
    logic [WAYS-1:0]          st_row;
    logic [KW-1:0]            st_key;
    logic [HANDLE_BITS-1:0]   st_handle;
    logic                     st_clr_busy;

    // datapath helpers
    logic [7:0]               hash_byte;
    logic [31:0]              rem32;
    logic [KW-1:0]            key_mask;
    logic                     key_match;
    logic                     way_valid;
    logic [HANDLE_BITS-1:0]   in_handle;
    logic [bht_pkg::HANDLE_W-1:0] out_handle;
    logic [WAYS-1:0]          row_add;
    logic [WAYS-1:0]          row_del;

    assign hash_byte = r_key[{r_cnt[2:0], 3'b000} +: 8];
    assign rem32     = {25'd0, alu_rem};
    assign way_valid = st_row[r_way];
    assign key_match = ((st_key ^ r_key[KW-1:0]) & key_mask) == '0;

    always_comb begin
        // compare only the configured low bytes
        for (int j = 0; j < KEY_BYTES; j++) begin
            key_mask[8*j +: 8] = (j < int'(kb_eff)) ? 8'hff : 8'h00;
        end
        // handle width conversions in and out
        in_handle          = '0;
        in_handle[HS-1:0]  = i_handle[HS-1:0];
        out_handle         = '0;
        out_handle[HS-1:0] = r_fhandle[HS-1:0];
        // row after an add into the free way or a delete of the hit way
        for (int w = 0; w < WAYS; w++) begin
            row_add[w] = st_row[w] | (WAY_W'(w) == r_free_way);
            row_del[w] = st_row[w] & (WAY_W'(w) != r_hit_way);
        end
    end

    bht_alu u_alu (
        .i_clk     (i_clk),
        .i_op      (alu_op),
        .i_byte    (hash_byte),
        .i_divisor (bc_eff),
        .o_rem     (alu_rem)
    );

    bht_store #(
        .BUCKETS     (BUCKETS),
        .WAYS        (WAYS),
        .KEY_BYTES   (KEY_BYTES),
        .HANDLE_BITS (HANDLE_BITS)
    ) u_store (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_ctrl      (st_ctrl),
        .i_bucket    (r_bucket),
        .i_row_wdata (st_row_wdata),
        .i_slot      (st_slot),
        .i_key_wdata (r_key[KW-1:0]),
        .i_hnd_wdata (r_handle),
        .o_row       (st_row),
        .o_key       (st_key),
        .o_handle    (st_handle),
        .o_clr_busy  (st_clr_busy)
    );

    assign o_in_ready = (r_state == bht_pkg::ST_IDLE) && !st_clr_busy;

    // ------------------------------------------------------------------
    // next state and control
    // ------------------------------------------------------------------
    always_comb begin
        n_state      = r_state;
        n_cnt        = r_cnt;
        n_req        = r_req;
        n_key        = r_key;
        n_handle     = r_handle;
        n_bucket     = r_bucket;
        n_base       = r_base;
        n_way        = r_way;
        n_hit        = r_hit;
        n_hit_way    = r_hit_way;
        n_free       = r_free;
        n_free_way   = r_free_way;
        n_fhandle    = r_fhandle;
        n_out_valid  = r_out_valid && !i_out_ready;
        n_status     = r_status;
        n_found      = r_found;
        alu_op       = bht_pkg::ALU_NOP;
        st_ctrl      = '0;
        st_slot      = r_base + SLOT_W'(r_way);
        st_row_wdata = st_row;

        unique case (r_state)
            bht_pkg::ST_IDLE: begin
                if (i_in_valid && o_in_ready) begin
                    n_req    = i_req_type;
                    n_key    = i_key;
                    n_handle = in_handle;
                    n_cnt    = '0;
                    alu_op   = bht_pkg::ALU_CLR;
                    n_state  = bht_pkg::ST_HASH;
                end
            end
            bht_pkg::ST_HASH: begin
                alu_op = bht_pkg::ALU_HASH;
                n_cnt  = r_cnt + 5'd1;
                if (r_cnt[3:0] == kb_eff - 4'd1) begin
                    n_cnt   = '0;
                    n_state = bht_pkg::ST_MOD;
                end
            end
            bht_pkg::ST_MOD: begin
                alu_op = bht_pkg::ALU_MOD;
                n_cnt  = r_cnt + 5'd1;
                if (r_cnt == 5'(bht_pkg::MOD_STEPS - 1)) begin
                    n_state = bht_pkg::ST_BASE;
                end
            end
            bht_pkg::ST_BASE: begin
                // remainder is below the bucket count, so it fits BKT_W
                n_bucket = rem32[BKT_W-1:0];
                n_base   = SLOT_W'(rem32 * WAYS);
                n_state  = bht_pkg::ST_ROW;
            end
            bht_pkg::ST_ROW: begin
                st_ctrl.row_rd = 1'b1;
                n_way   = '0;
                n_hit   = 1'b0;
                n_free  = 1'b0;
                n_state = bht_pkg::ST_RD;
            end
            bht_pkg::ST_RD: begin
                st_ctrl.slot_rd = 1'b1;
                n_state = bht_pkg::ST_CMP;
            end
            bht_pkg::ST_CMP: begin
                // first matching valid way, first free way
                if (way_valid) begin
                    if (!r_hit && key_match) begin
                        n_hit     = 1'b1;
                        n_hit_way = r_way;
                        n_fhandle = st_handle;
                    end
                end else if (!r_free) begin
                    n_free     = 1'b1;
                    n_free_way = r_way;
                end
                if (32'(r_way) == WAYS - 1) begin
                    n_state = bht_pkg::ST_FIN;
                end else begin
                    n_way   = r_way + 1'b1;
                    n_state = bht_pkg::ST_RD;
                end
            end
            bht_pkg::ST_FIN: begin
                st_slot = r_base + SLOT_W'(r_free_way);
                if (!r_out_valid || i_out_ready) begin
                    n_out_valid = 1'b1;
                    n_found     = '0;
                    n_state     = bht_pkg::ST_IDLE;
                    unique case (r_req)
                        bht_pkg::REQ_ADD: begin
                            if (r_hit) begin
                                n_status = bht_pkg::STS_DUPLICATE;
                            end else if (!r_free) begin
                                n_status = bht_pkg::STS_FULL;
                            end else begin
                                n_status        = bht_pkg::STS_OK;
                                st_ctrl.slot_we = 1'b1;
                                st_ctrl.row_we  = 1'b1;
                                st_row_wdata    = row_add;
                            end
                        end
                        bht_pkg::REQ_DELETE: begin
                            if (r_hit) begin
                                n_status       = bht_pkg::STS_OK;
                                n_found        = out_handle;
                                st_ctrl.row_we = 1'b1;
                                st_row_wdata   = row_del;
                            end else begin
                                n_status = bht_pkg::STS_NOT_FOUND;
                            end
                        end
                        default: begin
                            // lookup, and the unused code acting as one
                            if (r_hit) begin
                                n_status = bht_pkg::STS_OK;
                                n_found  = out_handle;
                            end else begin
                                n_status = bht_pkg::STS_NOT_FOUND;
                            end
                        end
                    endcase
                end
            end
            default: begin
                n_state = bht_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= bht_pkg::ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cnt      <= n_cnt;
        r_req      <= n_req;
        r_key      <= n_key;
        r_handle   <= n_handle;
        r_bucket   <= n_bucket;
        r_base     <= n_base;
        r_way      <= n_way;
        r_hit      <= n_hit;
        r_hit_way  <= n_hit_way;
        r_free     <= n_free;
        r_free_way <= n_free_way;
        r_fhandle  <= n_fhandle;
        r_status   <= n_status;
        r_found    <= n_found;
    end

    assign o_out_valid    = r_out_valid;
    assign o_status       = r_status;
    assign o_found_handle = r_found;

endmodule
`default_nettype wire

// ===== hdl/bht_alu.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// bht_alu: shared hash and modulo unit
// One DJB xor step per cycle, or two restoring remainder steps per cycle
// on the hash value, MSB first.
// ----------------------------------------------------------------------------
module bht_alu (
    input  wire                            i_clk,
    input  wire bht_pkg::t_alu_op          i_op,
    input  wire  [7:0]                     i_byte,
    input  wire  [bht_pkg::BC_W-1:0]       i_divisor,
    output logic [bht_pkg::BC_W-1:0]       o_rem
);

    logic [bht_pkg::HASH_W-1:0] r_h;
    logic [bht_pkg::HASH_W-1:0] n_h;
    logic [bht_pkg::BC_W-1:0]   r_rem;
    logic [bht_pkg::BC_W-1:0]   n_rem;
    logic [bht_pkg::BC_W:0]     t1;
    logic [bht_pkg::BC_W:0]     t2;
    logic [bht_pkg::BC_W:0]     dv;

    always_comb begin
        dv  = {1'b0, i_divisor};
        // remainder stays below the divisor, so one subtract per bit
        t1  = {r_rem, r_h[bht_pkg::HASH_W-1]};
        if (t1 >= dv) begin
            t1 = t1 - dv;
        end
        t2  = {t1[bht_pkg::BC_W-1:0], r_h[bht_pkg::HASH_W-2]};
        if (t2 >= dv) begin
            t2 = t2 - dv;
        end
        n_h   = r_h;
        n_rem = r_rem;
        unique case (i_op)
            bht_pkg::ALU_CLR: begin
                n_h   = '0;
                n_rem = '0;
            end
            bht_pkg::ALU_HASH: begin
                // 33*h = (h << 5) + h
                n_h = ((r_h << 5) + r_h) ^ {24'd0, i_byte};
            end
            bht_pkg::ALU_MOD: begin
                n_h   = r_h << 2;
                n_rem = t2[bht_pkg::BC_W-1:0];
            end
            bht_pkg::ALU_NOP: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_h   <= n_h;
        r_rem <= n_rem;
    end

    assign o_rem = r_rem;

endmodule
`default_nettype wire

// ===== hdl/bht_store.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// bht_store: slot storage of the bucket hash table
// Valid row per bucket, key and handle per slot, registered reads.
// Valid rows are swept to zero after reset.
// ----------------------------------------------------------------------------
module bht_store #(
    parameter int BUCKETS     = bht_pkg::BUCKETS_DEF,
    parameter int WAYS        = bht_pkg::WAYS_DEF,
    parameter int KEY_BYTES   = bht_pkg::KEY_BYTES_DEF,
    parameter int HANDLE_BITS = bht_pkg::HANDLE_BITS_DEF,
    localparam int SLOTS      = BUCKETS * WAYS,
    localparam int BKT_W      = (BUCKETS > 1) ? $clog2(BUCKETS) : 1,
    localparam int SLOT_W     = (SLOTS > 1) ? $clog2(SLOTS) : 1,
    localparam int KW         = 8 * KEY_BYTES
) (
    input  wire                     i_clk,
    input  wire                     i_rst_n,
    input  wire bht_pkg::t_st_ctrl  i_ctrl,
    input  wire  [BKT_W-1:0]        i_bucket,
    input  wire  [WAYS-1:0]         i_row_wdata,
    input  wire  [SLOT_W-1:0]       i_slot,
    input  wire  [KW-1:0]           i_key_wdata,
    input  wire  [HANDLE_BITS-1:0]  i_hnd_wdata,
    output logic [WAYS-1:0]         o_row,
    output logic [KW-1:0]           o_key,
    output logic [HANDLE_BITS-1:0]  o_handle,
    output logic                    o_clr_busy
);

    logic [WAYS-1:0]        row_mem [BUCKETS];
    logic [KW-1:0]          key_mem [SLOTS];
    logic [HANDLE_BITS-1:0] hnd_mem [SLOTS];

    logic             r_clr_busy;
    logic [BKT_W-1:0] r_clr_addr;

    // clearing sweep, one bucket row per cycle
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_busy <= 1'b1;
            r_clr_addr <= '0;
        end else if (r_clr_busy) begin
            r_clr_addr <= r_clr_addr + 1'b1;
            if (32'(r_clr_addr) == BUCKETS - 1) begin
                r_clr_busy <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_clr_busy) begin
            row_mem[r_clr_addr] <= '0;
        end else if (i_ctrl.row_we) begin
            row_mem[i_bucket] <= i_row_wdata;
        end
        if (i_ctrl.row_rd) begin
            o_row <= row_mem[i_bucket];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctrl.slot_we) begin
            key_mem[i_slot] <= i_key_wdata;
            hnd_mem[i_slot] <= i_hnd_wdata;
        end
        if (i_ctrl.slot_rd) begin
            o_key    <= key_mem[i_slot];
            o_handle <= hnd_mem[i_slot];
        end
    end

    assign o_clr_busy = r_clr_busy;

endmodule
`default_nettype wire
